FILE: src/tgr_pkg.sv
package tgr_pkg;

  // font and store geometry
  localparam int GLYPH_COUNT  = 256;
  localparam int MAX_SCALE    = 15;
  localparam int GLYPH_COLS   = 5;
  localparam int STORE_SIZE   = GLYPH_COUNT * GLYPH_COLS;
  localparam int GLYPH_ADDR_W = 11;
  localparam int COORD_W      = 18;

  // last column index of the 6x8 grid (blank column) and last row
  localparam logic [2:0] LAST_COL = 3'd5;
  localparam logic [2:0] LAST_ROW = 3'd7;

  // special characters
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;

  // register reset values
  localparam logic [11:0] WIDTH_RST    = 12'd240;
  localparam logic [11:0] HEIGHT_RST   = 12'd320;
  localparam logic [15:0] TEXT_COL_RST = 16'hFFFF;
  localparam logic [15:0] BG_COL_RST   = 16'hFFFF;
  localparam logic [3:0]  SIZE_RST     = 4'd1;
  localparam logic        WRAP_RST     = 1'b1;

  typedef enum logic [1:0] {
    REQ_CHAR   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_CURSOR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_TEXT_COLOR    = 3'd2,
    REG_TEXT_BG_COLOR = 3'd3,
    REG_TEXT_SIZE     = 3'd4,
    REG_WRAP_ENABLE   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CELL,
    ST_FETCH,
    ST_FLUSH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic ready;
    logic accept;
    logic do_prep;
    logic do_cell;
    logic do_flush;
  } tgr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_valid;
    logic draw_req;
    logic cell_blocked;
    logic flush_blocked;
    logic last_row;
    logic last_col;
    logic pend_valid;
  } tgr_sts_t;

  // scale factor with saturation
  function automatic logic [3:0] eff_size(logic [3:0] sz);
    logic [3:0] r;
    r = sz;
    if (int'(sz) > MAX_SCALE) begin
      r = 4'(MAX_SCALE);
    end
    return r;
  endfunction

endpackage

FILE: src/tgr_req_if.sv
interface tgr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         char_code;
  logic [10:0]        glyph_addr;
  logic [7:0]         glyph_byte;
  logic signed [15:0] new_cursor_x;
  logic signed [15:0] new_cursor_y;

  modport source (
    output valid, req_type, char_code, glyph_addr, glyph_byte, new_cursor_x, new_cursor_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, glyph_addr, glyph_byte, new_cursor_x, new_cursor_y,
    output ready
  );
endinterface

FILE: src/tgr_cell_if.sv
interface tgr_cell_if;
  logic        valid;
  logic        ready;
  logic [11:0] rect_x0;
  logic [11:0] rect_y0;
  logic [11:0] rect_x1;
  logic [11:0] rect_y1;
  logic [15:0] fill_color;
  logic        last_cell;

  modport source (
    output valid, rect_x0, rect_y0, rect_x1, rect_y1, fill_color, last_cell,
    input  ready
  );
  modport sink (
    input  valid, rect_x0, rect_y0, rect_x1, rect_y1, fill_color, last_cell,
    output ready
  );
endinterface

FILE: src/tgr_cfg_if.sv
interface tgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: src/tgr_ram.sv
module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1280
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tgr_ctrl.sv
module tgr_ctrl import tgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tgr_sts_t sts_i,
  output tgr_cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        if (sts_i.req_valid) begin
          cmd_o.accept = 1'b1;
          if (sts_i.draw_req) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd_o.do_prep = 1'b1;
        state_d       = ST_CELL;
      end
      ST_CELL: begin
        if (!sts_i.cell_blocked) begin
          cmd_o.do_cell = 1'b1;
          if (sts_i.last_row) begin
            state_d = sts_i.last_col ? ST_FLUSH : ST_FETCH;
          end
        end
      end
      // glyph store read of the next column is in flight
      ST_FETCH: begin
        state_d = ST_CELL;
      end
      ST_FLUSH: begin
        if (!sts_i.flush_blocked) begin
          cmd_o.do_flush = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/tgr_datapath.sv
module tgr_datapath import tgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgr_req_if.sink    req,
  tgr_cell_if.source cells,
  tgr_cfg_if.sink    cfg,
  input  tgr_cmd_t   cmd_i,
  output tgr_sts_t   sts_o
);

  // configuration registers
  logic [11:0] width_q, height_q;
  logic [15:0] tcol_q, bcol_q;
  logic [3:0]  tsize_q;
  logic        wrap_q;

  // cursor and per-character state
  logic [15:0] cx_q, cy_q;
  logic [GLYPH_ADDR_W-1:0] base_q;
  logic        blank_q;
  logic [2:0]  col_q, row_q;
  logic signed [COORD_W-1:0] x_q, y_q;

  // pending cell (held back until the next one shows whether it is the last)
  logic        pend_v_q;
  logic [11:0] pend_x0_q, pend_y0_q, pend_x1_q, pend_y1_q;
  logic [15:0] pend_col_q;

  // output register
  logic        out_v_q;
  logic [11:0] out_x0_q, out_y0_q, out_x1_q, out_y1_q;
  logic [15:0] out_col_q;
  logic        out_last_q;

  logic [3:0]  s;
  logic [6:0]  s6, s8;
  logic        wrap_hit;
  logic [15:0] cx_wr, cy_wr;
  logic signed [COORD_W-1:0] x_end, y_end, w_max, h_max;
  logic signed [COORD_W-1:0] cl_x0, cl_y0, cl_x1, cl_y1;
  logic        visible, pix_bit, has_color, emit;
  logic [15:0] pix_color;
  logic [7:0]  rd_data, line;
  logic [GLYPH_ADDR_W-1:0] rd_addr;
  logic        store_we;
  logic        out_free, push;

  assign cfg.ready = 1'b1;
  assign req.ready = cmd_i.ready;

  // scale-derived step sizes
  assign s  = eff_size(tsize_q);
  assign s6 = 7'({3'b0, s} * 7'd6);
  assign s8 = {s, 3'b0};

  // wrap to next line when the glyph would pass the right edge
  assign wrap_hit = wrap_q &&
    ($signed({{2{cx_q[15]}}, cx_q}) + $signed({11'b0, s6}) > $signed({6'b0, width_q}));
  assign cx_wr = wrap_hit ? 16'd0 : cx_q;
  assign cy_wr = wrap_hit ? cy_q + {9'b0, s8} : cy_q;

  // glyph store
  assign store_we = cmd_i.accept && (req_e'(req.req_type) == REQ_LOAD) &&
                    (int'(req.glyph_addr) < STORE_SIZE);
  assign rd_addr  = base_q + {8'b0, (col_q == LAST_COL) ? 3'd0 : col_q};

  tgr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (req.glyph_addr),
    .wdata_i (req.glyph_byte),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // cell color
  assign line      = ((col_q == LAST_COL) || blank_q) ? 8'd0 : rd_data;
  assign pix_bit   = line[row_q];
  assign has_color = pix_bit || (bcol_q != tcol_q);
  assign pix_color = pix_bit ? tcol_q : bcol_q;

  // clip cell to the screen
  assign x_end = x_q + $signed({14'b0, s}) - 18'sd1;
  assign y_end = y_q + $signed({14'b0, s}) - 18'sd1;
  assign w_max = $signed({6'b0, width_q}) - 18'sd1;
  assign h_max = $signed({6'b0, height_q}) - 18'sd1;
  assign cl_x0 = x_q[COORD_W-1] ? '0 : x_q;
  assign cl_y0 = y_q[COORD_W-1] ? '0 : y_q;
  assign cl_x1 = (x_end > w_max) ? w_max : x_end;
  assign cl_y1 = (y_end > h_max) ? h_max : y_end;
  assign visible = (cl_x0 <= cl_x1) && (cl_y0 <= cl_y1);
  assign emit    = has_color && visible;

  // output handoff
  assign out_free = !out_v_q || cells.ready;
  assign push     = pend_v_q && ((cmd_i.do_cell && emit) || cmd_i.do_flush);

  // status
  always_comb begin
    sts_o               = '0;
    sts_o.req_valid     = req.valid;
    sts_o.draw_req      = (req_e'(req.req_type) == REQ_CHAR) &&
                          (req.char_code != CHAR_NEWLINE) && (req.char_code != CHAR_CR);
    sts_o.cell_blocked  = emit && pend_v_q && !out_free;
    sts_o.flush_blocked = pend_v_q && !out_free;
    sts_o.last_row      = (row_q == LAST_ROW);
    sts_o.last_col      = (col_q == LAST_COL);
    sts_o.pend_valid    = pend_v_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      tcol_q   <= TEXT_COL_RST;
      bcol_q   <= BG_COL_RST;
      tsize_q  <= SIZE_RST;
      wrap_q   <= WRAP_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_e'(cfg.addr))
        REG_SCREEN_WIDTH:  width_q  <= cfg.data[11:0];
        REG_SCREEN_HEIGHT: height_q <= cfg.data[11:0];
        REG_TEXT_COLOR:    tcol_q   <= cfg.data;
        REG_TEXT_BG_COLOR: bcol_q   <= cfg.data;
        REG_TEXT_SIZE:     tsize_q  <= cfg.data[3:0];
        REG_WRAP_ENABLE:   wrap_q   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
    end else if (cmd_i.accept) begin
      case (req_e'(req.req_type))
        REQ_CHAR: begin
          if (req.char_code == CHAR_NEWLINE) begin
            cx_q <= '0;
            cy_q <= cy_q + {9'b0, s8};
          end
        end
        REQ_CURSOR: begin
          cx_q <= req.new_cursor_x;
          cy_q <= req.new_cursor_y;
        end
        default: ;
      endcase
    end else if (cmd_i.do_prep) begin
      cx_q <= cx_wr;
      cy_q <= cy_wr;
    end else if (cmd_i.do_flush) begin
      cx_q <= cx_q + {9'b0, s6};
    end
  end

  // grid walk, column by column and top to bottom
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      base_q  <= GLYPH_ADDR_W'({3'b0, req.char_code} * 11'd5);
      blank_q <= (int'(req.char_code) >= GLYPH_COUNT);
      col_q   <= '0;
      row_q   <= '0;
    end else if (cmd_i.do_prep) begin
      x_q <= $signed({{2{cx_wr[15]}}, cx_wr});
      y_q <= $signed({{2{cy_wr[15]}}, cy_wr});
    end else if (cmd_i.do_cell) begin
      if (row_q == LAST_ROW) begin
        row_q <= '0;
        col_q <= col_q + 3'd1;
        x_q   <= x_q + $signed({14'b0, s});
        y_q   <= $signed({{2{cy_q[15]}}, cy_q});
      end else begin
        row_q <= row_q + 3'd1;
        y_q   <= y_q + $signed({14'b0, s});
      end
    end
  end

  // pending cell valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.do_flush) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.do_cell && emit) begin
      pend_v_q <= 1'b1;
    end
  end

  // pending cell payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_cell && emit) begin
      pend_x0_q  <= cl_x0[11:0];
      pend_y0_q  <= cl_y0[11:0];
      pend_x1_q  <= cl_x1[11:0];
      pend_y1_q  <= cl_y1[11:0];
      pend_col_q <= pix_color;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (push) begin
      out_v_q <= 1'b1;
    end else if (cells.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_x0_q   <= pend_x0_q;
      out_y0_q   <= pend_y0_q;
      out_x1_q   <= pend_x1_q;
      out_y1_q   <= pend_y1_q;
      out_col_q  <= pend_col_q;
      out_last_q <= cmd_i.do_flush;
    end
  end

  assign cells.valid      = out_v_q;
  assign cells.rect_x0    = out_x0_q;
  assign cells.rect_y0    = out_y0_q;
  assign cells.rect_x1    = out_x1_q;
  assign cells.rect_y1    = out_y1_q;
  assign cells.fill_color = out_col_q;
  assign cells.last_cell  = out_last_q;

endmodule

FILE: src/text_glyph_rasterizer_unit.sv
// Text console rasterizer for a 5x8 font with a cursor.
// Channels: req (valid/ready) carries load, set-cursor and character beats;
// cells (valid/ready) carries one clipped, colored rectangle per beat, with
// last_cell set on the final rectangle of a character; cfg (valid/ready, always
// ready) writes the screen size, colors, scale and wrap registers by index.
// Load, set-cursor, newline, carriage return and undefined request beats are
// finished as they are taken and emit nothing. A drawable character is taken,
// has wrap applied, walks 48 cell slots (6 columns of 8 rows) with one read of
// the single glyph store read port per column after the first, and releases
// its final cell. One item is in work at a time; req is ready only between
// items. Each cell is held back until the next drawn cell shows whether it is
// last. A stalled receiver holds the cell walk at the next drawn cell once the
// output register and the held cell are both full; nothing is dropped. Reset
// clears the cursor to 0,0 and loads the default registers; the glyph store is
// not cleared and must be loaded before characters that use it are drawn.
module text_glyph_rasterizer_unit import tgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgr_req_if.sink    req,
  tgr_cell_if.source cells,
  tgr_cfg_if.sink    cfg
);

  tgr_cmd_t cmd;
  tgr_sts_t sts;

  tgr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tgr_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .cells  (cells),
    .cfg    (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // a cell step never overwrites a held cell that cannot leave
  a_cell_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_cell |-> !sts.cell_blocked)
    else $error("cell step while output path full");

  // the final cell leaves only when the output register has room
  a_flush_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_flush |-> !sts.flush_blocked)
    else $error("flush while output path full");

  // nothing stays held after a character completes
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_flush |=> !sts.pend_valid)
    else $error("held cell survived flush");

  // a new beat is taken only with no cell held from the previous character
  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !sts.pend_valid)
    else $error("beat taken while a cell is held");

endmodule
